FILE: hw/rtl/ieih_pkg.sv
// Shared types and constants for the inter-event interval histogram.
package ieih_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

  localparam logic [2:0] REG_MATCH_EVENT = 3'd0;
  localparam logic [2:0] REG_BIN_WIDTH   = 3'd1;
  localparam logic [2:0] REG_BINS_IN_USE = 3'd2;
  localparam logic [2:0] REG_START_SEC   = 3'd3;
  localparam logic [2:0] REG_START_USEC  = 3'd4;

  localparam logic [7:0]  MATCH_EVENT_RST = 8'd0;
  localparam logic [19:0] BIN_WIDTH_RST   = 20'd100;
  localparam logic [6:0]  BINS_IN_USE_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  event_code;
    logic [31:0] time_sec;
    logic [19:0] time_usec;
    logic [5:0]  bin_index;
  } req_t;

  typedef struct packed {
    logic [31:0] bin_lower_edge;
    logic [31:0] bin_count;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  match_event;
    logic [19:0] bin_width;
    logic [6:0]  bins_in_use;
    logic [31:0] start_sec;
    logic [19:0] start_usec;
  } cfg_t;

  typedef struct packed {
    logic load_req;
    logic clr_start;
    logic clr_step;
    logic mul_en;
    logic time_en;
    logic diff_en;
    logic div_en;
    logic sel_en;
    logic cnt_wr;
    logic bin_rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       code_match;
    logic       clr_last;
    logic       div_last;
    logic       out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/ieih_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ieih_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ieih_ctrl.sv
// Sequencer for the histogram: clear sweep, record, and read flows.
module ieih_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ieih_pkg::dp_sts_t sts_i,
  output ieih_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_TIME  = 10'b0000001000,
    S_DIFF  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_SEL   = 10'b0001000000,
    S_WRITE = 10'b0010000000,
    S_READ  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_req = 1'b1;
          case (ieih_pkg::cmd_e'(sts_i.command))
            ieih_pkg::CMD_RECORD: begin
              if (sts_i.code_match) begin
                state_d = S_MUL;
              end
            end
            ieih_pkg::CMD_READ: state_d = S_READ;
            ieih_pkg::CMD_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_TIME;
      end
      S_TIME: begin
        cmd_o.time_en = 1'b1;
        state_d       = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        cmd_o.sel_en = 1'b1;
        state_d      = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.cnt_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_READ: begin
        cmd_o.bin_rd = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/ieih_dp.sv
// Datapath: relative time, interval, bit-serial divide, bin counters, result register.
module ieih_dp #(
  parameter int unsigned NUM_BINS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ieih_pkg::cfg_t    cfg_i,
  input  ieih_pkg::req_t    in_req_i,
  input  ieih_pkg::dp_cmd_t cmd_i,
  output ieih_pkg::dp_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ieih_pkg::rsp_t    out_rsp_o
);

  localparam int unsigned AW = $clog2(NUM_BINS);

  ieih_pkg::req_t req_q;
  ieih_pkg::rsp_t rsp_q, rsp_d;
  logic           out_valid_q;

  logic [31:0]    prod_q, t_q, prev_q, quo_q;
  logic [19:0]    rem_q;
  logic [4:0]     step_q;
  logic           neg_q;
  logic [AW-1:0]  bin_q, clr_q, sel_bin;

  logic [31:0]    dsec, diff, idx32, last32, act32, n32;
  logic [20:0]    shifted;
  logic [21:0]    trial;
  logic           ge;
  logic [AW-1:0]  idx_addr;
  logic [31:0]    rdata, inc;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]    ram_wdata;

  // Divide step
  assign shifted = {rem_q, quo_q[31]};
  assign trial   = {1'b0, shifted} - {2'b00, cfg_i.bin_width};
  assign ge      = !trial[21];

  assign dsec = req_q.time_sec - cfg_i.start_sec;
  assign diff = t_q - prev_q;

  // Last bin in use
  assign n32    = (cfg_i.bins_in_use == 7'd0) ? 32'd1 : 32'(cfg_i.bins_in_use);
  assign act32  = (n32 > 32'(NUM_BINS)) ? 32'(NUM_BINS) : n32;
  assign last32 = act32 - 32'd1;

  always_comb begin
    if (neg_q) begin
      sel_bin = '0;
    end else if (quo_q > last32) begin
      sel_bin = last32[AW-1:0];
    end else begin
      sel_bin = quo_q[AW-1:0];
    end
  end

  assign idx32    = 32'(req_q.bin_index);
  assign idx_addr = idx32[AW-1:0];
  assign inc      = (&rdata) ? rdata : rdata + 32'd1;

  assign ram_we    = cmd_i.cnt_wr || cmd_i.clr_step;
  assign ram_waddr = cmd_i.cnt_wr ? bin_q : clr_q;
  assign ram_wdata = cmd_i.cnt_wr ? inc : '0;
  assign ram_re    = cmd_i.bin_rd || cmd_i.sel_en;
  assign ram_raddr = cmd_i.bin_rd ? idx_addr : sel_bin;

  ieih_ram #(
    .WIDTH(32),
    .DEPTH(NUM_BINS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    rsp_d.bin_lower_edge = idx32 * 32'(cfg_i.bin_width);
    rsp_d.bin_count      = (idx32 < 32'(NUM_BINS)) ? rdata : '0;
  end

  assign sts_o.command    = in_req_i.command;
  assign sts_o.code_match = (in_req_i.event_code == cfg_i.match_event);
  assign sts_o.clr_last   = (clr_q == AW'(NUM_BINS - 1));
  assign sts_o.div_last   = &step_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      prev_q      <= '0;
      step_q      <= '0;
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.clr_start) begin
        prev_q <= '0;
      end else if (cmd_i.diff_en) begin
        prev_q <= t_q;
      end
      if (cmd_i.diff_en) begin
        step_q <= '0;
      end else if (cmd_i.div_en) begin
        step_q <= step_q + 5'd1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= dsec * ieih_pkg::USEC_PER_SEC;
    end
    if (cmd_i.time_en) begin
      t_q <= prod_q + 32'(req_q.time_usec) - 32'(cfg_i.start_usec);
    end
    if (cmd_i.diff_en) begin
      neg_q <= diff[31];
      quo_q <= diff;
      rem_q <= '0;
    end else if (cmd_i.div_en) begin
      quo_q <= {quo_q[30:0], ge};
      rem_q <= ge ? trial[19:0] : shifted[19:0];
    end
    if (cmd_i.sel_en) begin
      bin_q <= sel_bin;
    end
    if (cmd_i.out_load) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

FILE: hw/rtl/inter_event_interval_histogram.sv
// Top level of the inter-event interval histogram: register port, sequencer, datapath.
//
// Requests enter on in_valid_i/in_req_i and are taken when in_stall_o is low.
// A record request whose event code matches match_event forms the time since
// the start time, subtracts the previous kept time and divides by bin_width,
// one quotient bit a cycle; the selected bin counter is then incremented with
// saturation. A record passes S_MUL, S_TIME, S_DIFF, the 32-step divide S_DIV, S_SEL
// and S_WRITE before the next request is taken; a non-matching record or unknown
// command ends at acceptance. A read request returns one response (bin lower edge
// and count) on out_valid_o/out_rsp_o after the RAM read in S_READ and the load
// of the output register in S_OUT; the response sits in an output register, so a
// stalled receiver only holds back a later read. A clear request sweeps the
// counter RAM, one bin a cycle; after reset the same sweep runs with in_stall_o
// high. Register writes over the APB port are accepted at all times and take
// effect at once, so they should be made while no request is in flight.
module inter_event_interval_histogram #(
  parameter int unsigned NUM_BINS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ieih_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ieih_pkg::req_t                in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ieih_pkg::rsp_t                out_rsp_o
);

  ieih_pkg::cfg_t    cfg_q;
  ieih_pkg::dp_cmd_t dp_cmd;
  ieih_pkg::dp_sts_t dp_sts;
  logic              wr_en;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_event <= ieih_pkg::MATCH_EVENT_RST;
      cfg_q.bin_width   <= ieih_pkg::BIN_WIDTH_RST;
      cfg_q.bins_in_use <= ieih_pkg::BINS_IN_USE_RST;
      cfg_q.start_sec   <= '0;
      cfg_q.start_usec  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        ieih_pkg::REG_MATCH_EVENT: cfg_q.match_event <= pwdata[7:0];
        ieih_pkg::REG_BIN_WIDTH:   cfg_q.bin_width   <= pwdata[19:0];
        ieih_pkg::REG_BINS_IN_USE: cfg_q.bins_in_use <= pwdata[6:0];
        ieih_pkg::REG_START_SEC:   cfg_q.start_sec   <= pwdata;
        ieih_pkg::REG_START_USEC:  cfg_q.start_usec  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ieih_pkg::REG_MATCH_EVENT: prdata = 32'(cfg_q.match_event);
      ieih_pkg::REG_BIN_WIDTH:   prdata = 32'(cfg_q.bin_width);
      ieih_pkg::REG_BINS_IN_USE: prdata = 32'(cfg_q.bins_in_use);
      ieih_pkg::REG_START_SEC:   prdata = cfg_q.start_sec;
      ieih_pkg::REG_START_USEC:  prdata = 32'(cfg_q.start_usec);
      default:                   prdata = '0;
    endcase
  end

  ieih_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  ieih_dp #(
    .NUM_BINS(NUM_BINS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_req_i   (in_req_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
